### rtl/pasr_pkg.sv
// Shared types and constants for the proxy ARP subnet relay.
package pasr_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'h06;
  localparam logic [7:0]  PROTO_UDP = 8'h11;
  localparam logic [7:0]  ARP_REQUEST = 8'h01;
  localparam logic [7:0]  ARP_REPLY   = 8'h02;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd34;

  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_ARP     = 2'd1,
    ACT_GATEWAY = 2'd2,
    ACT_CLIENT  = 2'd3
  } action_t;

  // Register byte addresses (8-byte stride)
  localparam logic [4:0] REG_RELAY_MAC  = 5'h00;
  localparam logic [4:0] REG_RELAY_IP   = 5'h08;
  localparam logic [4:0] REG_RELAY_MASK = 5'h10;
  localparam logic [4:0] REG_UPLINK_MAC = 5'h18;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [7:0]  opcode_low;
    logic [7:0]  ip_proto;
    logic [31:0] ip_source;
    logic [31:0] arp_sender_addr;
    logic [31:0] ip_dest;
    logic [31:0] arp_target_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] new_dst_mac;
    logic [47:0] new_src_mac;
    logic [7:0]  reply_opcode;
    logic [47:0] reply_sender_mac;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic        learned;
    logic        table_full;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_DROP  = 2'd0,
    CLS_ARP   = 2'd1,
    CLS_LOCAL = 2'd2,
    CLS_REMOTE = 2'd3
  } cls_t;

  // Classified item handed from front to back
  typedef struct packed {
    cls_t        cls;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] ip_source;
    logic [31:0] arp_sender_addr;
    logic [31:0] key_ip;
  } cls_item_t;

  typedef struct packed {
    logic [47:0] relay_mac;
    logic [31:0] relay_ip;
    logic [31:0] relay_mask;
    logic [47:0] uplink_mac;
  } cfg_regs_t;

endpackage

### rtl/pasr_front.sv
// Front end: takes input items and classifies them against the configuration.
module pasr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pasr_pkg::in_item_t   in_data,
  input  pasr_pkg::cfg_regs_t  cfg,
  output logic                 cls_valid,
  input  logic                 cls_ready,
  output pasr_pkg::cls_item_t  cls_data
);
  import pasr_pkg::*;

  logic      valid_r;
  cls_item_t data_r;
  cls_item_t data_nxt;
  logic      proto_ok;

  assign in_ready  = !valid_r || cls_ready;
  assign cls_valid = valid_r;
  assign cls_data  = data_r;

  assign proto_ok = (in_data.ip_proto == PROTO_TCP) || (in_data.ip_proto == PROTO_UDP);

  always_comb begin
    data_nxt.src_mac         = in_data.src_mac;
    data_nxt.dst_mac         = in_data.dst_mac;
    data_nxt.ip_source       = in_data.ip_source;
    data_nxt.arp_sender_addr = in_data.arp_sender_addr;
    data_nxt.key_ip          = in_data.ip_dest;
    data_nxt.cls             = CLS_DROP;
    if (in_data.frame_len < MIN_FRAME_LEN) begin
      data_nxt.cls = CLS_DROP;
    end else if (in_data.ether_type == ETH_ARP) begin
      data_nxt.key_ip = in_data.arp_target_addr;
      if (in_data.opcode_low == ARP_REQUEST) data_nxt.cls = CLS_ARP;
    end else if (in_data.ether_type == ETH_IPV4 && proto_ok &&
                 in_data.dst_mac == cfg.relay_mac &&
                 in_data.ip_source != cfg.relay_ip) begin
      if ((in_data.ip_source & cfg.relay_mask) == (cfg.relay_ip & cfg.relay_mask))
        data_nxt.cls = CLS_LOCAL;
      else
        data_nxt.cls = CLS_REMOTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) data_r <= data_nxt;
  end
endmodule

### rtl/pasr_queue.sv
// Short FIFO between the classifier and the table engine.
module pasr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  pasr_pkg::cls_item_t  wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output pasr_pkg::cls_item_t  rd_data
);
  import pasr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cls_item_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [PW:0]       cnt_r;
  logic              push, pop;

  assign wr_ready = cnt_r != (PW+1)'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

### rtl/pasr_back.sv
// Back end: client table search, learning and result formation.
module pasr_back #(
  parameter int unsigned TABLE_ENTRIES = pasr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  pasr_pkg::cls_item_t  q_data,
  input  pasr_pkg::cfg_regs_t  cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pasr_pkg::out_item_t  out_data
);
  import pasr_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_READ   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [31:0]     ip_mem [TABLE_ENTRIES];
  logic [47:0]     mac_mem [TABLE_ENTRIES];
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   idx_r;
  logic            hit_r;
  logic [IW-1:0]   hit_idx_r;
  logic [31:0]     ip_rd_r;
  logic [47:0]     mac_rd_r;
  logic            rd_pend_r;
  cls_item_t       item_r;
  out_item_t       res_r;
  out_item_t       res_nxt;
  logic            res_valid_r;
  logic            match;
  logic            do_write;
  logic [IW-1:0]   rd_addr;

  // One entry read per cycle; compare the registered read in the next.
  assign match = (item_r.cls == CLS_LOCAL) ? (mac_rd_r == item_r.src_mac)
                                           : (ip_rd_r == item_r.key_ip);
  assign rd_addr = (state_r == ST_READ) ? hit_idx_r : idx_r[IW-1:0];
  assign do_write = (state_r == ST_DONE) && !res_valid_r && item_r.cls == CLS_LOCAL &&
                    !hit_r && count_r < CW'(TABLE_ENTRIES);

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (rd_pend_r && match) state_nxt = (item_r.cls == CLS_REMOTE) ? ST_READ : ST_DONE;
        else if (!rd_pend_r && idx_r >= count_r) state_nxt = ST_DONE;
      end
      ST_READ:   state_nxt = ST_DONE;
      ST_DONE:   if (res_valid_r && out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Result of the held item; mac_rd_r holds the hit entry's MAC after ST_READ.
  always_comb begin
    res_nxt = '0;
    unique case (item_r.cls)
      CLS_ARP: if (hit_r) begin
        res_nxt.action           = ACT_ARP;
        res_nxt.new_dst_mac      = item_r.src_mac;
        res_nxt.new_src_mac      = cfg.relay_mac;
        res_nxt.reply_opcode     = ARP_REPLY;
        res_nxt.reply_sender_mac = cfg.relay_mac;
        res_nxt.reply_sender_ip  = item_r.key_ip;
        res_nxt.reply_target_mac = item_r.src_mac;
        res_nxt.reply_target_ip  = item_r.arp_sender_addr;
      end
      CLS_LOCAL: begin
        res_nxt.action      = ACT_GATEWAY;
        res_nxt.new_dst_mac = cfg.uplink_mac;
        res_nxt.new_src_mac = cfg.relay_mac;
        res_nxt.learned     = do_write;
        res_nxt.table_full  = !hit_r && !do_write;
      end
      CLS_REMOTE: if (hit_r) begin
        res_nxt.action      = ACT_CLIENT;
        res_nxt.new_dst_mac = mac_rd_r;
        res_nxt.new_src_mac = item_r.dst_mac;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ip_rd_r  <= ip_mem[rd_addr];
    mac_rd_r <= mac_mem[rd_addr];
    if (do_write) begin
      ip_mem[count_r[IW-1:0]]  <= item_r.ip_source;
      mac_mem[count_r[IW-1:0]] <= item_r.src_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          idx_r     <= '0;
          hit_r     <= 1'b0;
          rd_pend_r <= 1'b0;
          if (q_valid) item_r <= q_data;
        end
        ST_SEARCH: begin
          // Issue read of idx_r; check the one issued last cycle.
          if (rd_pend_r && match) begin
            hit_r     <= 1'b1;
            rd_pend_r <= 1'b0;
            hit_idx_r <= IW'(idx_r - 1'b1);
          end else if (idx_r < count_r && item_r.cls != CLS_DROP) begin
            rd_pend_r <= 1'b1;
            idx_r     <= idx_r + 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            idx_r     <= count_r;
          end
        end
        ST_READ: ;
        ST_DONE: begin
          if (!res_valid_r) begin
            res_valid_r <= 1'b1;
            res_r       <= res_nxt;
            if (do_write) count_r <= count_r + 1'b1;
          end else if (out_ready) begin
            res_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/proxy_arp_subnet_relay.sv
// Top level of the proxy ARP subnet relay.
// Each item is one frame header; the relay returns one rewrite decision per item.
// The front classifies an item into a register and queues it (two entries); the back
// takes one item at a time and scans the client table one entry per cycle. The scan
// stops at a hit or at the table count; a remote lookup that hits then fetches the
// client MAC in ST_READ, and the back holds its result until out_ready takes it.
// The table is read at one address a cycle; that scan sets the throughput.
// Learning appends at the current count.
// Configuration registers sit at byte addresses 0x00, 0x08, 0x10, 0x18 and
// should be written only while the relay is idle.
module proxy_arp_subnet_relay #(
  parameter int unsigned TABLE_ENTRIES = pasr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pasr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pasr_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import pasr_pkg::*;

  cfg_regs_t cfg_r;
  logic      wr_en;
  logic      f_valid, f_ready, b_valid, b_ready;
  cls_item_t f_data, b_data;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes; unknown addresses drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (cfg_paddr)
        REG_RELAY_MAC:  cfg_r.relay_mac  <= cfg_pwdata[47:0];
        REG_RELAY_IP:   cfg_r.relay_ip   <= cfg_pwdata[31:0];
        REG_RELAY_MASK: cfg_r.relay_mask <= cfg_pwdata[31:0];
        REG_UPLINK_MAC: cfg_r.uplink_mac <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_RELAY_MAC:  cfg_prdata = {16'd0, cfg_r.relay_mac};
      REG_RELAY_IP:   cfg_prdata = {32'd0, cfg_r.relay_ip};
      REG_RELAY_MASK: cfg_prdata = {32'd0, cfg_r.relay_mask};
      REG_UPLINK_MAC: cfg_prdata = {16'd0, cfg_r.uplink_mac};
      default:        cfg_prdata = '0;
    endcase
  end

  pasr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cfg(cfg_r),
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
  );

  pasr_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  pasr_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data), .cfg(cfg_r),
    .out_valid, .out_ready, .out_data
  );
endmodule

### rtl/pasr_checker.sv
// Port-level checker for the relay, bound to the top level.
module pasr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input pasr_pkg::out_item_t out_data,
  input logic                cfg_pready
);
  import pasr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.learned && out_data.table_full))
    else $error("learned and table_full both set");

  a_flags_gw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.learned || out_data.table_full) |->
      out_data.action == ACT_GATEWAY)
    else $error("learning flag outside gateway forwarding");

  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_ARP |-> out_data.reply_opcode == ARP_REPLY)
    else $error("reply opcode wrong");

  a_ready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind proxy_arp_subnet_relay pasr_checker u_pasr_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data, .cfg_pready
);
